/* hdl/mma_pkg.sv */
// Shared types, constants, saturation helpers and a dimension clamp for the matrix multiply-accumulate block.
// No dependencies.
package mma_pkg;

  localparam int MAX_DIM = 8;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int DIM_W   = 4;
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int AB_W    = 16;
  localparam int C_W     = 48;
  localparam int PROD_W  = 2 * AB_W;
  localparam int ACC_W   = C_W + 3;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    FUNC_LOAD_A  = 2'd0,
    FUNC_LOAD_B  = 2'd1,
    FUNC_LOAD_C  = 2'd2,
    FUNC_COMPUTE = 2'd3
  } func_e;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_OF_A  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_OF_B  = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

  // one multiply step entering the MAC
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic             zero;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             final_elem;
  } mma_step_t;

  // a finished C element leaving the MAC
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             final_elem;
  } mma_done_t;

  function automatic logic [AB_W-1:0] sat16(input logic [C_W-1:0] v);
    logic all_same;
    all_same = (v[C_W-1:AB_W-1] == '0) || (v[C_W-1:AB_W-1] == '1);
    if (all_same) begin
      return v[AB_W-1:0];
    end else if (v[C_W-1]) begin
      return {1'b1, {(AB_W-1){1'b0}}};
    end else begin
      return {1'b0, {(AB_W-1){1'b1}}};
    end
  endfunction

  function automatic logic [C_W-1:0] sat48(input logic [ACC_W-1:0] v);
    logic all_same;
    all_same = (v[ACC_W-1:C_W-1] == '0) || (v[ACC_W-1:C_W-1] == '1);
    if (all_same) begin
      return v[C_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(C_W-1){1'b0}}};
    end else begin
      return {1'b0, {(C_W-1){1'b1}}};
    end
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    return (d > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : d;
  endfunction

endpackage

/* hdl/mma_if.sv */
// Valid/ready channel interfaces: item input, result output, register write.
// Depends on mma_pkg.
interface mma_in_if import mma_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              func;
  logic [IDX_W-1:0]        row_index;
  logic [IDX_W-1:0]        col_index;
  logic signed [C_W-1:0]   element_value;

  modport source (output valid, func, row_index, col_index, element_value, input ready);
  modport sink   (input valid, func, row_index, col_index, element_value, output ready);
endinterface

interface mma_out_if import mma_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [C_W-1:0]   result_value;
  logic [IDX_W-1:0]        result_row;
  logic [IDX_W-1:0]        result_col;
  logic                    last_result;

  modport source (output valid, result_value, result_row, result_col, last_result,
                  input ready);
  modport sink   (input valid, result_value, result_row, result_col, last_result,
                  output ready);
endinterface

interface mma_cfg_if import mma_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/mma_mac.sv */
// Multiply and accumulate stages with final 48-bit saturation.
// Depends on mma_pkg.
module mma_mac import mma_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  mma_step_t         step_i,
  input  logic [AB_W-1:0]   a_i,
  input  logic [AB_W-1:0]   b_i,
  input  logic [C_W-1:0]    c_i,
  output logic              busy_o,
  output mma_done_t         done_o,
  output logic [C_W-1:0]    sum_o
);

  mma_step_t          step_q;
  logic [PROD_W-1:0]  prod_q;
  logic [C_W-1:0]     c_q;
  logic [ACC_W-1:0]   acc_q, acc_d;
  mma_done_t          done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= '0;
    end else if (en_i) begin
      step_q       <= step_i;
      done_q.valid <= step_q.valid && step_q.last;
      done_q.row   <= step_q.row;
      done_q.col   <= step_q.col;
      done_q.final_elem <= step_q.final_elem;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && step_i.valid) begin
      prod_q <= step_i.zero ? '0 : PROD_W'($signed(a_i) * $signed(b_i));
      c_q    <= c_i;
    end
  end

  always_comb begin
    if (step_q.first) begin
      acc_d = ACC_W'($signed(c_q)) + ACC_W'($signed(prod_q));
    end else begin
      acc_d = acc_q + ACC_W'($signed(prod_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && step_q.valid) begin
      acc_q <= acc_d;
    end
  end

  assign busy_o = step_q.valid || done_q.valid;
  assign done_o = done_q;
  assign sum_o  = sat48(acc_q);

endmodule

/* hdl/matrix_multiply_accumulate.sv */
// Top level of the matrix multiply-accumulate block: A, B, C stores, sequencer, result register.
// Depends on mma_pkg, the channel interfaces in mma_if.sv and mma_mac.
//
//   channel  dir  beat
//   in_i     in   func, row_index, col_index, element_value
//   res_o    out  result_value, result_row, result_col, last_result
//   cfg_i    in   register index, 4-bit write data
//
// A load beat goes straight into its store. A compute beat issues one read of each store
// per cycle unless frozen, rows*cols*max(inner,1) steps through the single MAC; the next
// beat waits for the pipeline to drain. Reset clears control and sets all dimensions to 8;
// the stores are not cleared. A stalled result register freezes the whole MAC pipeline.
module matrix_multiply_accumulate import mma_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  mma_in_if.sink    in_i,
  mma_out_if.source res_o,
  mma_cfg_if.sink   cfg_i
);

  logic [DIM_W-1:0] rows_q, inner_q, cols_q;
  logic [DIM_W-1:0] n1, n2, n3, steps;

  logic [AB_W-1:0] a_mem [MAX_DIM*MAX_DIM];
  logic [AB_W-1:0] b_mem [MAX_DIM*MAX_DIM];
  logic [C_W-1:0]  c_mem [MAX_DIM*MAX_DIM];
  logic [AB_W-1:0] a_rd_q, b_rd_q;
  logic [C_W-1:0]  c_rd_q;

  logic             iss_q;
  logic [IDX_W-1:0] i_q, j_q, k_q;
  mma_step_t        step_d, step_q;

  logic             mac_busy;
  mma_done_t        done;
  logic [C_W-1:0]   sum;

  logic             en, in_acc, start;
  logic             k_end, j_end, i_end;
  logic             c_we;
  logic [ADDR_W-1:0] c_waddr;
  logic [C_W-1:0]   c_wdata;

  logic             out_v_q;
  logic [C_W-1:0]   out_val_q;
  logic [IDX_W-1:0] out_row_q, out_col_q;
  logic             out_last_q;

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= DIM_RESET;
      inner_q <= DIM_RESET;
      cols_q  <= DIM_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_ROWS_OF_A:  rows_q  <= cfg_i.data;
        CFG_INNER_SIZE: inner_q <= cfg_i.data;
        CFG_COLS_OF_B:  cols_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign n1    = clamp_dim(rows_q);
  assign n2    = clamp_dim(inner_q);
  assign n3    = clamp_dim(cols_q);
  assign steps = (n2 == '0) ? DIM_W'(1) : n2;

  // pipeline freezes while a finished element cannot enter the result register
  assign en = !(done.valid && out_v_q && !res_o.ready);

  assign in_i.ready = !iss_q && !step_q.valid && !mac_busy;
  assign in_acc     = in_i.valid && in_i.ready;
  assign start      = in_acc && (func_e'(in_i.func) == FUNC_COMPUTE) &&
                      (n1 != '0) && (n3 != '0);

  // sequencer over i, j, k
  assign k_end = ({1'b0, k_q} == steps - DIM_W'(1));
  assign j_end = ({1'b0, j_q} == n3 - DIM_W'(1));
  assign i_end = ({1'b0, i_q} == n1 - DIM_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q <= 1'b0;
      i_q   <= '0;
      j_q   <= '0;
      k_q   <= '0;
    end else if (start) begin
      iss_q <= 1'b1;
      i_q   <= '0;
      j_q   <= '0;
      k_q   <= '0;
    end else if (en && iss_q) begin
      if (k_end) begin
        k_q <= '0;
        if (j_end) begin
          j_q <= '0;
          if (i_end) begin
            iss_q <= 1'b0;
          end else begin
            i_q <= i_q + IDX_W'(1);
          end
        end else begin
          j_q <= j_q + IDX_W'(1);
        end
      end else begin
        k_q <= k_q + IDX_W'(1);
      end
    end
  end

  always_comb begin
    step_d.valid      = iss_q;
    step_d.first      = (k_q == '0);
    step_d.last       = k_end;
    step_d.zero       = (n2 == '0);
    step_d.row        = i_q;
    step_d.col        = j_q;
    step_d.final_elem = i_end && j_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (en) begin
      step_q <= step_d;
    end
  end

  // stores: one write port each, registered read
  always_ff @(posedge clk_i) begin
    if (en && iss_q) begin
      a_rd_q <= a_mem[{i_q, k_q}];
      b_rd_q <= b_mem[{k_q, j_q}];
      c_rd_q <= c_mem[{i_q, j_q}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (func_e'(in_i.func) == FUNC_LOAD_A)) begin
      a_mem[{in_i.row_index, in_i.col_index}] <= sat16(in_i.element_value);
    end
    if (in_acc && (func_e'(in_i.func) == FUNC_LOAD_B)) begin
      b_mem[{in_i.row_index, in_i.col_index}] <= sat16(in_i.element_value);
    end
    if (c_we) begin
      c_mem[c_waddr] <= c_wdata;
    end
  end

  // loads and write-back never overlap: loads are taken only with the pipeline empty
  always_comb begin
    if (done.valid) begin
      c_we    = en;
      c_waddr = {done.row, done.col};
      c_wdata = sum;
    end else begin
      c_we    = in_acc && (func_e'(in_i.func) == FUNC_LOAD_C);
      c_waddr = {in_i.row_index, in_i.col_index};
      c_wdata = in_i.element_value;
    end
  end

  mma_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .step_i (step_q),
    .a_i    (a_rd_q),
    .b_i    (b_rd_q),
    .c_i    (c_rd_q),
    .busy_o (mac_busy),
    .done_o (done),
    .sum_o  (sum)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (done.valid && en) begin
      out_v_q <= 1'b1;
    end else if (res_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done.valid && en) begin
      out_val_q  <= sum;
      out_row_q  <= done.row;
      out_col_q  <= done.col;
      out_last_q <= done.final_elem;
    end
  end

  assign res_o.valid        = out_v_q;
  assign res_o.result_value = out_val_q;
  assign res_o.result_row   = out_row_q;
  assign res_o.result_col   = out_col_q;
  assign res_o.last_result  = out_last_q;

endmodule
